// ===== hdl/bf_tape_machine_core_top_defines.svh =====
// Assertion helpers for the tape machine core.
`ifndef BF_TAPE_MACHINE_CORE_TOP_DEFINES_SVH
`define BF_TAPE_MACHINE_CORE_TOP_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define BFT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define BFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bft_pkg.sv =====
package bft_pkg;

  localparam logic [2:0] ST_EXEC     = 3'd0;
  localparam logic [2:0] ST_HALT     = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_UNDER    = 3'd3;
  localparam logic [2:0] ST_OVER     = 3'd4;
  localparam logic [2:0] ST_LOADED   = 3'd5;

  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'd91;
  localparam logic [7:0] CH_CLOSE = 8'd93;

  localparam logic REQ_LOAD = 1'b0;

  typedef struct packed {
    logic        req_type;
    logic [11:0] prog_addr;
    logic [7:0]  prog_byte;
    logic [7:0]  in_byte;
    logic        in_eof;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        out_valid;
    logic [15:0] out_value;
    logic        input_used;
    logic [12:0] next_pc;
    logic [31:0] steps_done;
  } out_item_t;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_FETCH = 7'b0000100,
    S_PEEK1 = 7'b0001000,
    S_PEEK2 = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_EVAL  = 7'b1000000
  } state_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_PC,
    RD_PC1,
    RD_PC2,
    RD_SCAN
  } rd_sel_e;

  typedef enum logic [3:0] {
    FIN_NONE,
    FIN_LOAD,
    FIN_FAULT,
    FIN_HALT,
    FIN_SIMPLE,
    FIN_CLEAR,
    FIN_SKIP1,
    FIN_JUMP,
    FIN_MISMATCH
  } fin_e;

  typedef struct packed {
    logic    accept;
    logic    load_wr;
    rd_sel_e rd_sel;
    logic    scan_init;
    logic    scan_fwd;
    logic    scan_step;
    logic    scan_eval;
    logic    clr_wr;
    fin_e    fin;
  } cmd_t;

  typedef struct packed {
    logic faulted;
    logic halted;
    logic out_busy;
    logic op_open;
    logic op_close;
    logic byte_minus;
    logic cell_zero;
    logic scan_edge;
    logic scan_hit;
    logic clr_last;
  } stat_t;

endpackage

// ===== hdl/bft_datapath.sv =====
module bft_datapath
  import bft_pkg::*;
#(
  parameter int PROG_DEPTH = 4096,
  parameter int TAPE_DEPTH = 1024,
  parameter int CELL_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_item_i,
  input  logic        cfg_valid_i,
  input  logic [12:0] cfg_data_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output out_item_t   out_item_o
);

  localparam int AW = $clog2(PROG_DEPTH);
  localparam int PW = AW + 1;
  localparam int TW = $clog2(TAPE_DEPTH);
  localparam int LW = (PW > 13) ? PW : 13;

  logic [7:0]            prog_mem [PROG_DEPTH];
  logic [CELL_WIDTH-1:0] tape_mem [TAPE_DEPTH];

  logic [12:0]           len_q;
  logic [PW-1:0]         pc_q, p_q, lvl_q;
  logic [TW-1:0]         tp_q, clr_q;
  logic [31:0]           steps_q;
  logic [2:0]            fault_q;
  logic                  fwd_q, ieof_q, prog_ok_q, out_vq;
  logic [7:0]            ibyte_q, prog_q;
  logic [CELL_WIDTH-1:0] cell_rd_q;
  out_item_t             out_q;

  logic [LW-1:0]         len_w;
  logic [PW-1:0]         len_eff, rd_addr, p_next, npc;
  logic [7:0]            byte_eff;
  logic                  tape_we, exec, run_kind;
  logic [TW-1:0]         tape_wa, tp_nx;
  logic [CELL_WIDTH-1:0] tape_wd;
  logic [2:0]            st;
  logic                  ov, used;
  logic [15:0]           oval;

  assign len_w   = (LW'(len_q) > LW'(PROG_DEPTH)) ? LW'(PROG_DEPTH) : LW'(len_q);
  assign len_eff = PW'(len_w);
  assign byte_eff = prog_ok_q ? prog_q : 8'd0;
  assign p_next  = fwd_q ? p_q + PW'(1) : p_q - PW'(1);

  always_comb begin
    rd_addr = pc_q;
    unique case (cmd_i.rd_sel)
      RD_PC:   rd_addr = pc_q;
      RD_PC1:  rd_addr = pc_q + PW'(1);
      RD_PC2:  rd_addr = pc_q + PW'(2);
      RD_SCAN: rd_addr = p_next;
      default: rd_addr = pc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && (int'(in_item_i.prog_addr) < PROG_DEPTH)) begin
      prog_mem[AW'(in_item_i.prog_addr)] <= in_item_i.prog_byte;
    end
    if (cmd_i.rd_sel != RD_NONE) begin
      prog_q    <= prog_mem[rd_addr[AW-1:0]];
      prog_ok_q <= rd_addr < len_eff;
    end
  end

  // Execute the finishing command.
  always_comb begin
    st      = ST_EXEC;
    npc     = pc_q + PW'(1);
    ov      = 1'b0;
    oval    = 16'd0;
    used    = 1'b0;
    tp_nx   = tp_q;
    tape_we = 1'b0;
    tape_wa = tp_q;
    tape_wd = '0;
    unique case (cmd_i.fin)
      FIN_LOAD:  st = ST_LOADED;
      FIN_FAULT: st = fault_q;
      FIN_HALT:  st = ST_HALT;
      FIN_SIMPLE: begin
        case (byte_eff)
          CH_GT: begin
            if (tp_q == TW'(TAPE_DEPTH - 1)) st = ST_OVER;
            else tp_nx = tp_q + TW'(1);
          end
          CH_LT: begin
            if (tp_q == '0) st = ST_UNDER;
            else tp_nx = tp_q - TW'(1);
          end
          CH_PLUS: begin
            tape_we = 1'b1;
            tape_wd = cell_rd_q + CELL_WIDTH'(1);
          end
          CH_MINUS: begin
            tape_we = 1'b1;
            tape_wd = cell_rd_q - CELL_WIDTH'(1);
          end
          CH_DOT: begin
            ov   = 1'b1;
            oval = 16'(cell_rd_q);
          end
          CH_COMMA: begin
            tape_we = 1'b1;
            tape_wd = ieof_q ? '0 : CELL_WIDTH'(ibyte_q);
            used    = !ieof_q;
          end
          default: ;
        endcase
      end
      FIN_CLEAR: begin
        tape_we = 1'b1;
        npc     = pc_q + PW'(3);
      end
      FIN_SKIP1:    ;
      FIN_JUMP:     npc = fwd_q ? p_q + PW'(1) : p_q;
      FIN_MISMATCH: st = ST_MISMATCH;
      default:      ;
    endcase
    if (cmd_i.clr_wr) begin
      tape_we = 1'b1;
      tape_wa = clr_q;
      tape_wd = '0;
    end
  end

  assign run_kind = cmd_i.fin inside {FIN_SIMPLE, FIN_CLEAR, FIN_SKIP1, FIN_JUMP, FIN_MISMATCH};
  assign exec     = run_kind && (st == ST_EXEC);

  always_ff @(posedge clk_i) begin
    if (tape_we) tape_mem[tape_wa] <= tape_wd;
    cell_rd_q <= tape_mem[tp_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      pc_q    <= '0;
      tp_q    <= '0;
      steps_q <= '0;
      fault_q <= ST_EXEC;
      clr_q   <= '0;
      out_vq  <= 1'b0;
    end else begin
      if (cfg_valid_i) len_q <= cfg_data_i;
      if (cmd_i.clr_wr) clr_q <= clr_q + TW'(1);
      if (exec) begin
        pc_q    <= npc;
        tp_q    <= tp_nx;
        steps_q <= steps_q + 32'd1;
      end else if (run_kind) begin
        fault_q <= st;
      end
      if (cmd_i.fin != FIN_NONE) out_vq <= 1'b1;
      else if (!out_stall_i) out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ibyte_q <= in_item_i.in_byte;
      ieof_q  <= in_item_i.in_eof;
    end
    if (cmd_i.scan_init) begin
      p_q   <= pc_q;
      lvl_q <= PW'(1);
      fwd_q <= cmd_i.scan_fwd;
    end
    if (cmd_i.scan_step) p_q <= p_next;
    if (cmd_i.scan_eval) begin
      if (stat_o.op_open) lvl_q <= fwd_q ? lvl_q + PW'(1) : lvl_q - PW'(1);
      else if (stat_o.op_close) lvl_q <= fwd_q ? lvl_q - PW'(1) : lvl_q + PW'(1);
    end
    if (cmd_i.fin != FIN_NONE) begin
      out_q.status     <= st;
      out_q.out_valid  <= ov;
      out_q.out_value  <= oval;
      out_q.input_used <= used;
      out_q.next_pc    <= exec ? 13'(npc) : 13'(pc_q);
      out_q.steps_done <= exec ? steps_q + 32'd1 : steps_q;
    end
  end

  assign stat_o.faulted    = fault_q != ST_EXEC;
  assign stat_o.halted     = !(pc_q < len_eff);
  assign stat_o.out_busy   = out_vq;
  assign stat_o.op_open    = byte_eff == CH_OPEN;
  assign stat_o.op_close   = byte_eff == CH_CLOSE;
  assign stat_o.byte_minus = byte_eff == CH_MINUS;
  assign stat_o.cell_zero  = cell_rd_q == '0;
  assign stat_o.scan_edge  = fwd_q ? ((p_q + PW'(1)) >= len_eff)
                                   : ((p_q == '0) || ((p_q - PW'(1)) >= len_eff));
  assign stat_o.scan_hit   = (lvl_q == PW'(1)) &&
                             (fwd_q ? (byte_eff == CH_CLOSE) : (byte_eff == CH_OPEN));
  assign stat_o.clr_last   = clr_q == TW'(TAPE_DEPTH - 1);

  assign out_valid_o = out_vq;
  assign out_item_o  = out_q;

endmodule

// ===== hdl/bft_ctrl.sv =====
module bft_ctrl
  import bft_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  req_type_i,
  input  stat_t stat_i,
  output logic  in_stall_o,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   minus_q, minus_d;
  logic   acc;

  assign in_stall_o = (state_q != S_IDLE) || stat_i.out_busy;
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    minus_d = minus_q;
    cmd_o   = '{accept: 1'b0, load_wr: 1'b0, rd_sel: RD_NONE, scan_init: 1'b0,
                scan_fwd: 1'b0, scan_step: 1'b0, scan_eval: 1'b0, clr_wr: 1'b0,
                fin: FIN_NONE};
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          cmd_o.accept = 1'b1;
          if (req_type_i == REQ_LOAD) begin
            cmd_o.load_wr = 1'b1;
            cmd_o.fin     = FIN_LOAD;
          end else if (stat_i.faulted) begin
            cmd_o.fin = FIN_FAULT;
          end else if (stat_i.halted) begin
            cmd_o.fin = FIN_HALT;
          end else begin
            cmd_o.rd_sel = RD_PC;
            state_d      = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (stat_i.op_open) begin
          cmd_o.rd_sel = RD_PC1;
          state_d      = S_PEEK1;
        end else if (stat_i.op_close) begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end else begin
          cmd_o.fin = FIN_SIMPLE;
          state_d   = S_IDLE;
        end
      end
      S_PEEK1: begin
        minus_d      = stat_i.byte_minus;
        cmd_o.rd_sel = RD_PC2;
        state_d      = S_PEEK2;
      end
      S_PEEK2: begin
        if (minus_q && stat_i.op_close) begin
          cmd_o.fin = FIN_CLEAR;
          state_d   = S_IDLE;
        end else if (stat_i.cell_zero) begin
          cmd_o.scan_init = 1'b1;
          cmd_o.scan_fwd  = 1'b1;
          state_d         = S_SCAN;
        end else begin
          cmd_o.fin = FIN_SKIP1;
          state_d   = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_edge) begin
          cmd_o.fin = FIN_MISMATCH;
          state_d   = S_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
          cmd_o.rd_sel    = RD_SCAN;
          state_d         = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.scan_eval = 1'b1;
        if (stat_i.scan_hit) begin
          cmd_o.fin = FIN_JUMP;
          state_d   = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      minus_q <= 1'b0;
    end else begin
      state_q <= state_d;
      minus_q <= minus_d;
    end
  end

endmodule

// ===== hdl/bf_tape_machine_core_top.sv =====
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_stall_o  | in_item_i (in_item_t)
// out     | output    | out_valid_o / out_stall_i| out_item_o (out_item_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_data_i (program length)
//
// Loads, halted steps and faulted steps are settled from the idle state; a
// plain command does a program read, then executes. A [ adds two look-ahead
// reads, and a bracket walk reads each program byte visited, then evaluates
// it, through the single program memory read port. A new item is taken only
// once the output register is empty. After reset a clearing pass zeroes the
// tape cell by cell, with items held off; config writes are always taken.
`include "bf_tape_machine_core_top_defines.svh"

module bf_tape_machine_core_top
  import bft_pkg::*;
#(
  parameter int PROG_DEPTH = 4096,
  parameter int TAPE_DEPTH = 1024,
  parameter int CELL_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  // Config register is written at any time.
  assign cfg_ready_o = 1'b1;

  // Sequence each item (load, fetch, look ahead, walk brackets) and the tape clear after reset.
  bft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_item_i.req_type),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // Hold program and tape memories, machine registers and the output item.
  bft_datapath #(
    .PROG_DEPTH (PROG_DEPTH),
    .TAPE_DEPTH (TAPE_DEPTH),
    .CELL_WIDTH (CELL_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  `BFT_ASSERT_NOW(a_accept_out_empty, clk_i, rst_ni, in_valid_i && !in_stall_o, !out_valid_o, "item accepted while a result is pending")
  `BFT_ASSERT_NEXT(a_load_result, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_item_i.req_type == REQ_LOAD), out_valid_o && (out_item_o.status == ST_LOADED), "load item did not report loaded")

endmodule
